// ===== design/hcbb_pkg.sv =====
// hcbb_pkg: shared types and constants for the hex command bus bridge.
// No dependencies; used by hcbb_decode and hex_command_bus_bridge_top.
package hcbb_pkg;

	typedef enum logic [3:0] {
		ACT_WR_BYTE = 4'd0,
		ACT_WR_HALF = 4'd1,
		ACT_WR_WORD = 4'd2,
		ACT_RD_BYTE = 4'd3,
		ACT_RD_HALF = 4'd4,
		ACT_RD_WORD = 4'd5,
		ACT_BULK_RD = 4'd6,
		ACT_JUMP    = 4'd7,
		ACT_OTHER   = 4'd8
	} action_t;

	localparam logic [7:0] CH_IDLE   = 8'hFF;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CMD_IDLE  = 8'h7A;
	localparam logic [7:0] CMD_SEND  = 8'h53;
	localparam logic [7:0] CMD_WR_B  = 8'h4F;
	localparam logic [7:0] CMD_WR_H  = 8'h48;
	localparam logic [7:0] CMD_WR_W  = 8'h57;
	localparam logic [7:0] CMD_RD_B  = 8'h6F;
	localparam logic [7:0] CMD_RD_H  = 8'h68;
	localparam logic [7:0] CMD_RD_W  = 8'h77;
	localparam logic [7:0] CMD_BULK  = 8'h52;
	localparam logic [7:0] CMD_JUMP  = 8'h47;
	localparam logic [3:0] HEX_ALPHA = 4'hA;

	typedef struct packed {
		logic       idle;
		logic       hash;
		logic       comma;
		logic       digit;
		logic [3:0] nibble;
	} char_class_t;

endpackage

// ===== design/hex_command_bus_bridge_top.sv =====
// hex_command_bus_bridge_top: ASCII hex monitor parser emitting bus actions.
// Depends on hcbb_pkg and hcbb_decode.
// Stages: the input register byte_s1, then the output register that holds each result.
// Throughput: one word per cycle; the input stage advances whenever the output register is
// empty or being taken. Parser state is updated once per word in the second stage.
// Reset (arst_n low, async): both stages empty, number/address/payload cleared, command 'z'.
module hex_command_bus_bridge_top #(
	parameter int ADDR_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata   // [3:0] action, [35:4] bus_address,
	                                   // [67:36] bus_value, [75:68] command_char, rest zero
);
	import hcbb_pkg::*;

	localparam int AW = (ADDR_BITS < 32) ? ADDR_BITS : 32;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          advance;

	logic [31:0]   number_q;
	logic [AW-1:0] address_q;
	logic [7:0]    command_q;
	logic [31:0]   payload_left_q;
	logic [AW-1:0] payload_ptr_q;

	action_t       out_action_q;
	logic [31:0]   out_addr_q;
	logic [31:0]   out_value_q;
	logic [7:0]    out_cmd_q;

	char_class_t   cls;
	action_t       cmd_action;
	logic          cmd_is_send;
	logic          in_payload;
	logic          do_step;

	logic          res_valid;
	action_t       res_action;
	logic [31:0]   res_addr;
	logic [31:0]   res_value;
	logic [7:0]    res_cmd;

	hcbb_decode u_decode (
		.rx_byte (byte_s1),
		.command (command_q),
		.cls     (cls),
		.action  (cmd_action),
		.is_send (cmd_is_send)
	);

	assign advance       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_payload    = (payload_left_q != '0);
	assign do_step       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// result of the current word
	always_comb begin
		res_valid  = 1'b0;
		res_action = ACT_OTHER;
		res_addr   = 32'(address_q);
		res_value  = number_q;
		res_cmd    = command_q;
		if (in_payload) begin
			res_valid  = 1'b1;
			res_action = ACT_WR_BYTE;
			res_addr   = 32'(payload_ptr_q);
			res_value  = 32'(byte_s1);
			res_cmd    = CMD_SEND;
		end else if (cls.hash && !cmd_is_send) begin
			res_valid  = 1'b1;
			res_action = cmd_action;
			case (cmd_action) inside
				ACT_WR_BYTE: res_value = 32'(number_q[7:0]);
				ACT_WR_HALF: res_value = 32'(number_q[15:0]);
				ACT_RD_BYTE, ACT_RD_HALF, ACT_RD_WORD: res_value = '0;
				ACT_JUMP: begin
					res_addr  = number_q;
					res_value = '0;
				end
				default: res_value = number_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_q       <= '0;
			address_q      <= '0;
			command_q      <= CMD_IDLE;
			payload_left_q <= '0;
			payload_ptr_q  <= '0;
		end else if (do_step) begin
			if (in_payload) begin
				payload_ptr_q  <= payload_ptr_q + AW'(1);
				payload_left_q <= payload_left_q - 32'd1;
			end else if (cls.idle) begin
				number_q <= number_q;
			end else if (cls.hash) begin
				if (cmd_is_send) begin
					payload_left_q <= number_q;
					payload_ptr_q  <= address_q;
				end
				command_q <= CMD_IDLE;
				number_q  <= '0;
			end else if (cls.digit) begin
				number_q <= {number_q[27:0], cls.nibble};
			end else if (cls.comma) begin
				address_q <= number_q[AW-1:0];
				number_q  <= '0;
			end else begin
				command_q <= byte_s1;
				number_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= do_step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step && res_valid) begin
			out_action_q <= res_action;
			out_addr_q   <= res_addr;
			out_value_q  <= res_value;
			out_cmd_q    <= res_cmd;
		end
	end

	assign m_axis_tdata = {4'b0, out_cmd_q, out_value_q, out_addr_q, out_action_q};

	// payload words always produce a byte write
	a_payload_emits: assert property (@(posedge clk) disable iff (!arst_n)
		do_step && in_payload |=> m_axis_tvalid && out_cmd_q == CMD_SEND
			&& out_action_q == ACT_WR_BYTE)
		else $error("payload word lost");

	// execute returns parser to idle command and clears the number
	a_exec_clears: assert property (@(posedge clk) disable iff (!arst_n)
		do_step && !in_payload && byte_s1 == CH_HASH |=> command_q == CMD_IDLE && number_q == '0)
		else $error("execute did not clear parser");

	// send command never emits its own result
	a_send_silent: assert property (@(posedge clk) disable iff (!arst_n)
		do_step && !in_payload && byte_s1 == CH_HASH && command_q == CMD_SEND |=> !m_axis_tvalid)
		else $error("send command emitted a result");

endmodule

// ===== design/hcbb_decode.sv =====
// hcbb_decode: classifies a received byte and maps the pending command to an action.
// Depends on hcbb_pkg.
module hcbb_decode (
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           command,
	output hcbb_pkg::char_class_t cls,
	output hcbb_pkg::action_t    action,
	output logic                 is_send
);
	import hcbb_pkg::*;

	always_comb begin
		cls        = '0;
		cls.idle   = (rx_byte == CH_IDLE);
		cls.hash   = (rx_byte == CH_HASH);
		cls.comma  = (rx_byte == CH_COMMA);
		if (rx_byte >= "0" && rx_byte <= "9") begin
			cls.digit  = 1'b1;
			cls.nibble = 4'(rx_byte - 8'("0"));
		end else if (rx_byte >= "A" && rx_byte <= "F") begin
			cls.digit  = 1'b1;
			cls.nibble = 4'(rx_byte - 8'("A")) + HEX_ALPHA;
		end else if (rx_byte >= "a" && rx_byte <= "f") begin
			cls.digit  = 1'b1;
			cls.nibble = 4'(rx_byte - 8'("a")) + HEX_ALPHA;
		end
	end

	always_comb begin
		is_send = (command == CMD_SEND);
		unique case (command)
			CMD_WR_B: action = ACT_WR_BYTE;
			CMD_WR_H: action = ACT_WR_HALF;
			CMD_WR_W: action = ACT_WR_WORD;
			CMD_RD_B: action = ACT_RD_BYTE;
			CMD_RD_H: action = ACT_RD_HALF;
			CMD_RD_W: action = ACT_RD_WORD;
			CMD_BULK: action = ACT_BULK_RD;
			CMD_JUMP: action = ACT_JUMP;
			default:  action = ACT_OTHER;
		endcase
	end

endmodule

// ===== dv/hcbb_checker.sv =====
// hcbb_checker: watches both stream channels of the hex command bus bridge,
// predicts each bus action from the accepted input bytes and compares results.
// Depends on hcbb_pkg.
`timescale 1ns / 100ps
module hcbb_checker #(
	parameter int ADDR_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [79:0] out_data,
	output int          fail_count,
	output int          pending,
	output int          checked
);
	import hcbb_pkg::*;

	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;

	typedef struct {
		action_t     act;
		logic [31:0] addr;
		logic [31:0] val;
		logic [7:0]  cmd;
	} bus_op_t;

	bus_op_t     ops_due[$];
	logic [31:0] number_q;
	logic [31:0] addr_q;
	logic [31:0] left_q;
	logic [31:0] ptr_q;
	logic [7:0]  cmd_q;
	int          fails;
	int          n_checked;

	function automatic logic [31:0] addr_mask();
		if (ADDR_BITS >= 32)
			return '1;
		return (32'd1 << ADDR_BITS) - 32'd1;
	endfunction

	task automatic parse_byte(input logic [7:0] b);
		bus_op_t op;
		logic    emit;
		emit    = 1'b0;
		op.act  = ACT_OTHER;
		op.addr = addr_q;
		op.val  = number_q;
		op.cmd  = cmd_q;
		if (left_q != 0) begin
			op     = '{ACT_WR_BYTE, ptr_q, {24'd0, b}, CMD_SEND};
			emit   = 1'b1;
			ptr_q  = (ptr_q + 32'd1) & addr_mask();
			left_q = left_q - 32'd1;
		end else if (b == CH_HASH) begin
			emit = 1'b1;
			case (cmd_q)
				CMD_SEND: begin
					left_q = number_q;
					ptr_q  = addr_q & addr_mask();
					emit   = 1'b0;
				end
				CMD_WR_B: begin
					op.act = ACT_WR_BYTE;
					op.val = number_q & 32'hFF;
				end
				CMD_WR_H: begin
					op.act = ACT_WR_HALF;
					op.val = number_q & 32'hFFFF;
				end
				CMD_WR_W: op.act = ACT_WR_WORD;
				CMD_RD_B: begin
					op.act = ACT_RD_BYTE;
					op.val = '0;
				end
				CMD_RD_H: begin
					op.act = ACT_RD_HALF;
					op.val = '0;
				end
				CMD_RD_W: begin
					op.act = ACT_RD_WORD;
					op.val = '0;
				end
				CMD_BULK: op.act = ACT_BULK_RD;
				CMD_JUMP: begin
					op.act  = ACT_JUMP;
					op.addr = number_q;
					op.val  = '0;
				end
				default: ;
			endcase
			cmd_q    = CMD_IDLE;
			number_q = '0;
		end else if (b == CH_IDLE) begin
		end else if (b >= CH_ZERO && b <= CH_NINE) begin
			number_q = {number_q[27:0], 4'(b - CH_ZERO)};
		end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
			number_q = {number_q[27:0], 4'(b - CH_UPPER_A) + HEX_ALPHA};
		end else if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
			number_q = {number_q[27:0], 4'(b - CH_LOWER_A) + HEX_ALPHA};
		end else if (b == CH_COMMA) begin
			addr_q   = number_q & addr_mask();
			number_q = '0;
		end else begin
			cmd_q    = b;
			number_q = '0;
		end
		if (emit)
			ops_due.push_back(op);
	endtask

	task automatic check_result();
		bus_op_t want;
		if (ops_due.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("unexpected result word %h", out_data);
			return;
		end
		want = ops_due.pop_front();
		n_checked++;
		if (out_data[3:0] !== want.act || out_data[35:4] !== want.addr ||
		    out_data[67:36] !== want.val || out_data[75:68] !== want.cmd ||
		    out_data[79:76] !== 4'd0) begin
			fails++;
			if (fails <= 10) begin
				$display("mismatch: exp act=%0d addr=%h val=%h cmd=%h",
				         want.act, want.addr, want.val, want.cmd);
				$display("          got act=%0d addr=%h val=%h cmd=%h pad=%h",
				         out_data[3:0], out_data[35:4], out_data[67:36],
				         out_data[75:68], out_data[79:76]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ops_due.delete();
			number_q   = '0;
			addr_q     = '0;
			left_q     = '0;
			ptr_q      = '0;
			cmd_q      = CMD_IDLE;
			fails      = 0;
			n_checked  = 0;
			pending    <= 0;
			fail_count <= 0;
			checked    <= 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				parse_byte(in_data);
			pending    <= ops_due.size();
			fail_count <= fails;
			checked    <= n_checked;
		end
	end

endmodule

// ===== dv/hex_command_bus_bridge_top_tb.sv =====
// hex_command_bus_bridge_top_tb: drives hex command text, payload bursts and noise into
// the bridge under varied stream pacing; verdict comes from hcbb_checker.
// Depends on hcbb_pkg, hcbb_checker and hex_command_bus_bridge_top.
`timescale 1ns / 100ps
module hex_command_bus_bridge_top_tb;
	import hcbb_pkg::*;

	localparam int         ADDR_BITS    = 32;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         RANDOM_WORDS = 480;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_F   = 8'h46;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_LOWER_F   = 8'h66;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;

	int send_idle_pct = 26;
	int recv_idle_pct = 61;
	int stall_left = 0;
	int words_sent = 0;
	int cycles = 0;
	int fail_count;
	int pending;
	int checked;

	hex_command_bus_bridge_top #(.ADDR_BITS(ADDR_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	hcbb_checker #(.ADDR_BITS(ADDR_BITS)) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_data(s_axis_tdata),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data(m_axis_tdata),
		.fail_count(fail_count),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("** hex_command_bus_bridge_top: FAILED **");
			$finish;
		end
	end

	// receiver pacing; stall_left forces a long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
		if (nib < HEX_ALPHA)
			return CH_ZERO + 8'(nib);
		return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(nib - HEX_ALPHA);
	endfunction

	task automatic send_word(input logic [7:0] b, input bit counted = 1'b1);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (counted)
			words_sent++;
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_word(s[i]);
	endtask

	task automatic send_hex(input int digits);
		repeat (digits)
			send_word(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
	endtask

	task automatic send_count(input int count);
		int ndig;
		ndig = 2 + $urandom_range(2);
		for (int i = ndig - 1; i >= 0; i--)
			send_word(hex_char(4'((count >> (4 * i)) & 15), 1'($urandom_range(1))));
	endtask

	task automatic send_payload(input int n);
		repeat (n)
			send_word(8'($urandom_range(255)));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// one command line: [addr ,] cmd [value] #, or a burst of noise with no execute
	task automatic send_sequence();
		logic [7:0] cmd;
		int         count;
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(1, 6)) begin
				cmd = 8'($urandom_range(255));
				if (cmd == CH_HASH)
					cmd = CH_COMMA;
				send_word(cmd, cmd != CH_IDLE);
			end
			return;
		end
		if ($urandom_range(9) != 0) begin
			send_hex($urandom_range(0, 10));
			send_word(CH_COMMA);
		end
		case ($urandom_range(10))
			0: cmd = CMD_WR_B;
			1: cmd = CMD_WR_H;
			2: cmd = CMD_WR_W;
			3: cmd = CMD_RD_B;
			4: cmd = CMD_RD_H;
			5: cmd = CMD_RD_W;
			6: cmd = CMD_BULK;
			7: cmd = CMD_JUMP;
			8: cmd = CMD_SEND;
			9: cmd = CMD_IDLE;
			default: begin
				do
					cmd = 8'($urandom_range(255));
				while ((cmd >= CH_ZERO && cmd <= CH_NINE) ||
				       (cmd >= CH_UPPER_A && cmd <= CH_UPPER_F) ||
				       (cmd >= CH_LOWER_A && cmd <= CH_LOWER_F) ||
				       cmd == CH_COMMA || cmd == CH_HASH || cmd == CH_IDLE ||
				       cmd == CMD_SEND);
			end
		endcase
		send_word(cmd);
		if ($urandom_range(3) == 0)
			send_word(CH_IDLE, 1'b0);
		if (cmd == CMD_SEND) begin
			count = ($urandom_range(15) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 6);
			send_count(count);
			send_word(CH_HASH);
			send_payload(count);
		end else begin
			send_hex($urandom_range(0, 10));
			send_word(CH_HASH);
		end
		if ($urandom_range(9) == 0)
			send_word(CH_HASH);
	endtask

	initial begin
		int target;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle execute, idle byte, full-width address, payload wrapping past the top
		send_word(CH_HASH);
		send_word(CH_IDLE, 1'b0);
		send_text("FfFFfFFf,W9a#G5#S3#");
		send_word(CH_IDLE);
		send_word(CH_HASH);
		send_word(CH_COMMA);
		send_text("S#x7#");
		drain();

		// output held off while a payload burst keeps offering words
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_left = 80;
		send_text("S28#");
		send_payload(40);
		drain();

		target = words_sent;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 26;
					recv_idle_pct = 61;
				end
				1: begin
					send_idle_pct = 61;
					recv_idle_pct = 26;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			target += RANDOM_WORDS / 3;
			while (words_sent < target)
				send_sequence();
			drain();
		end

		repeat (10) @(posedge clk);
		$display("Covered %0d input words: directed text, hex command lines, payload bursts, noise.",
		         words_sent);
		$display("Checked %0d results over three pacing modes plus a long output stall.", checked);
		if (fail_count == 0) begin
			$display("** hex_command_bus_bridge_top: PASSED **");
		end else begin
			$display("%0d failures", fail_count);
			$display("** hex_command_bus_bridge_top: FAILED **");
		end
		$finish;
	end

endmodule
